FILE: design/fsm_pkg.sv
`default_nettype none
package fsm_pkg;

  localparam int MEM_BYTES      = 4096;
  localparam int DATA_STACK_GAP = 256;
  localparam int ADDR_W         = $clog2(MEM_BYTES);
  localparam int PTR_W          = ADDR_W + 1;
  localparam int CELL_W         = 32;

  localparam logic [PTR_W-1:0] CELL_STEP = PTR_W'(4);
  localparam logic [PTR_W-1:0] DP_RESET  = PTR_W'(MEM_BYTES - DATA_STACK_GAP);
  localparam logic [PTR_W-1:0] RP_RESET  = PTR_W'(MEM_BYTES);

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_STEP  = 2'd2;

  localparam logic [7:0] OP_BYE     = 8'd0;
  localparam logic [7:0] OP_QRX     = 8'd1;
  localparam logic [7:0] OP_TX      = 8'd2;
  localparam logic [7:0] OP_IO      = 8'd3;
  localparam logic [7:0] OP_DOLIT   = 8'd4;
  localparam logic [7:0] OP_DOLIST  = 8'd5;
  localparam logic [7:0] OP_NEXT    = 8'd6;
  localparam logic [7:0] OP_QBRANCH = 8'd7;
  localparam logic [7:0] OP_BRANCH  = 8'd8;
  localparam logic [7:0] OP_EXECUTE = 8'd9;
  localparam logic [7:0] OP_EXIT    = 8'd10;
  localparam logic [7:0] OP_STORE   = 8'd11;
  localparam logic [7:0] OP_FETCH   = 8'd12;
  localparam logic [7:0] OP_CSTORE  = 8'd13;
  localparam logic [7:0] OP_CFETCH  = 8'd14;
  localparam logic [7:0] OP_RPFETCH = 8'd15;
  localparam logic [7:0] OP_RPSTORE = 8'd16;
  localparam logic [7:0] OP_DTOR    = 8'd17;
  localparam logic [7:0] OP_RFETCH  = 8'd18;
  localparam logic [7:0] OP_RTOD    = 8'd19;
  localparam logic [7:0] OP_SPFETCH = 8'd20;
  localparam logic [7:0] OP_SPSTORE = 8'd21;
  localparam logic [7:0] OP_DROP    = 8'd22;
  localparam logic [7:0] OP_DUP     = 8'd23;
  localparam logic [7:0] OP_SWAP    = 8'd24;
  localparam logic [7:0] OP_OVER    = 8'd25;
  localparam logic [7:0] OP_LESS    = 8'd26;
  localparam logic [7:0] OP_AND     = 8'd27;
  localparam logic [7:0] OP_OR      = 8'd28;
  localparam logic [7:0] OP_XOR     = 8'd29;
  localparam logic [7:0] OP_UMPLUS  = 8'd30;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_OPW   = 3'd2;
  localparam logic [2:0] S_EXEC  = 3'd3;
  localparam logic [2:0] S_RD    = 3'd4;
  localparam logic [2:0] S_WR    = 3'd5;

endpackage
`default_nettype wire

FILE: design/forth_stack_machine_core.sv
// Byte-coded Forth stack machine with program, data and both stacks in one
// byte-wide synchronous memory (one write and one read per cycle).
// Input channel: in_valid/in_stall with in_command, in_address, in_byte_value.
// Output channel: out_valid/out_stall, one result per accepted input.
// Load, start and ignored commands are answered from the idle state; their
// result is registered at the accepting edge, so these can be sent back to back.
// An executed instruction passes through the opcode read (S_OPW) and the
// dispatch (S_EXEC), then through each cell or byte read (S_RD) and write
// (S_WR) it needs, with a dispatch in S_EXEC after each one. The single
// byte port of the memory serialises every one of these accesses.
// in_stall is high while an instruction runs and while a finished result
// waits under out_stall; a stalled result holds its value.
// After reset the memory is cleared one byte per cycle, with in_stall high,
// until all 4096 bytes are zero.
`default_nettype none
module forth_stack_machine_core
  import fsm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] in_command,
  input  wire logic [11:0] in_address,
  input  wire logic [7:0] in_byte_value,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            out_char_valid,
  output logic [7:0]      out_char_out,
  output logic            out_halted,
  output logic            out_bad_opcode
);

  logic [7:0] mem [MEM_BYTES];

  logic [2:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] clr_r, clr_nxt;
  logic [ADDR_W-1:0] pc_r, pc_nxt;
  logic [PTR_W-1:0]  dp_r, dp_nxt, rp_r, rp_nxt;
  logic [7:0]        depth_r, depth_nxt;
  logic              run_r, run_nxt;
  logic [7:0]        op_r, op_nxt;
  logic [2:0]        step_r, step_nxt;
  logic [CELL_W-1:0] a_r, a_nxt, b_r, b_nxt, rd_r, rd_nxt, wd_r, wd_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic              len4_r, len4_nxt;
  logic [2:0]        cnt_r, cnt_nxt;
  logic              ov_r, ov_nxt, cv_r, cv_nxt, hl_r, hl_nxt, bad_r, bad_nxt;
  logic [7:0]        ch_r, ch_nxt;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [7:0]        mem_wdata, mem_rdata_r;

  logic              in_accept;
  logic              go_rd, go_wr, go_len4, fin;
  logic [ADDR_W-1:0] go_addr;
  logic [CELL_W-1:0] go_wdata;
  logic [PTR_W-1:0]  dp_up, dp_dn, rp_up, rp_dn;
  logic [ADDR_W-1:0] pc4;
  logic [7:0]        depth_inc;
  logic [1:0]        rd_idx;
  logic [2:0]        cnt_last;

  assign in_stall  = (state_r != S_IDLE) || (ov_r && out_stall);
  assign in_accept = in_valid && !in_stall;

  assign out_valid      = ov_r;
  assign out_char_valid = cv_r;
  assign out_char_out   = ch_r;
  assign out_halted     = hl_r;
  assign out_bad_opcode = bad_r;

  assign dp_up     = dp_r + CELL_STEP;
  assign dp_dn     = dp_r - CELL_STEP;
  assign rp_up     = rp_r + CELL_STEP;
  assign rp_dn     = rp_r - CELL_STEP;
  assign pc4       = pc_r + ADDR_W'(4);
  assign depth_inc = (depth_r == 8'hFF) ? depth_r : depth_r + 8'd1;
  assign rd_idx    = cnt_r[1:0] - 2'd1;
  assign cnt_last  = len4_r ? 3'd4 : 3'd1;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_r <= mem[mem_raddr];
  end

  always_comb begin
    state_nxt = state_r;  clr_nxt = clr_r;   pc_nxt = pc_r;
    dp_nxt = dp_r;        rp_nxt = rp_r;     depth_nxt = depth_r;
    run_nxt = run_r;      op_nxt = op_r;     step_nxt = step_r;
    a_nxt = a_r;          b_nxt = b_r;       rd_nxt = rd_r;
    wd_nxt = wd_r;        addr_nxt = addr_r; len4_nxt = len4_r;
    cnt_nxt = cnt_r;
    ov_nxt = ov_r && out_stall;
    cv_nxt = cv_r;  ch_nxt = ch_r;  hl_nxt = hl_r;  bad_nxt = bad_r;
    mem_we = 1'b0;  mem_waddr = addr_r;  mem_wdata = 8'd0;  mem_raddr = pc_r;
    go_rd = 1'b0;  go_wr = 1'b0;  go_len4 = 1'b1;  fin = 1'b0;
    go_addr = dp_r[ADDR_W-1:0];  go_wdata = rd_r;

    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        clr_nxt   = clr_r + ADDR_W'(1);
        if (clr_r == {ADDR_W{1'b1}}) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          if (in_command == CMD_STEP && run_r) begin
            state_nxt = S_OPW;
          end else begin
            ov_nxt = 1'b1;  cv_nxt = 1'b0;  ch_nxt = 8'd0;
            hl_nxt = 1'b0;  bad_nxt = 1'b0;
            if (in_command == CMD_LOAD) begin
              mem_we    = 1'b1;
              mem_waddr = in_address;
              mem_wdata = in_byte_value;
            end else if (in_command == CMD_START) begin
              pc_nxt    = in_address;
              depth_nxt = 8'd1;
              run_nxt   = 1'b1;
            end
          end
        end
      end
      S_OPW: begin
        op_nxt    = mem_rdata_r;
        pc_nxt    = pc_r + ADDR_W'(1);
        step_nxt  = 3'd0;
        state_nxt = S_EXEC;
      end
      S_RD: begin
        mem_raddr = addr_r + ADDR_W'(cnt_r);
        if (cnt_r != 3'd0) begin
          rd_nxt[{rd_idx, 3'b000} +: 8] = mem_rdata_r;
        end
        if (cnt_r == cnt_last) begin
          state_nxt = S_EXEC;
        end else begin
          cnt_nxt = cnt_r + 3'd1;
        end
      end
      S_WR: begin
        mem_we    = 1'b1;
        mem_waddr = addr_r + ADDR_W'(cnt_r);
        mem_wdata = wd_r[{cnt_r[1:0], 3'b000} +: 8];
        if (cnt_r == cnt_last - 3'd1) begin
          state_nxt = S_EXEC;
        end else begin
          cnt_nxt = cnt_r + 3'd1;
        end
      end
      S_EXEC: begin
        unique case (op_r) inside
          OP_BYE: begin
            run_nxt = 1'b0;  hl_nxt = 1'b1;  fin = 1'b1;
          end
          OP_QRX, OP_IO, OP_NEXT, OP_LESS: fin = 1'b1;
          OP_TX: begin
            if (step_r == 3'd0) begin
              go_rd = 1'b1;  dp_nxt = dp_dn;
            end else begin
              cv_nxt = 1'b1;  ch_nxt = rd_r[7:0];  fin = 1'b1;
            end
          end
          OP_DOLIT: begin
            if (step_r == 3'd0) begin
              go_rd = 1'b1;  go_addr = pc_r;
            end else if (step_r == 3'd1) begin
              go_wr = 1'b1;  go_addr = dp_up[ADDR_W-1:0];  dp_nxt = dp_up;
              pc_nxt = pc4;
            end else begin
              fin = 1'b1;
            end
          end
          OP_DOLIST: begin
            if (step_r == 3'd0) begin
              go_rd = 1'b1;  go_addr = pc_r;
            end else if (step_r == 3'd1) begin
              a_nxt = rd_r;  rp_nxt = rp_dn;
              go_wr = 1'b1;  go_addr = rp_dn[ADDR_W-1:0];
              go_wdata = CELL_W'(pc4);
            end else begin
              pc_nxt = a_r[ADDR_W-1:0];  depth_nxt = depth_inc;  fin = 1'b1;
            end
          end
          OP_QBRANCH: begin
            if (step_r == 3'd0) begin
              go_rd = 1'b1;  dp_nxt = dp_dn;
            end else if (step_r == 3'd1) begin
              if (rd_r != '0) begin
                go_rd = 1'b1;  go_addr = pc_r;
              end else begin
                pc_nxt = pc4;  fin = 1'b1;
              end
            end else begin
              pc_nxt = rd_r[ADDR_W-1:0];  fin = 1'b1;
            end
          end
          OP_BRANCH: begin
            if (step_r == 3'd0) begin
              go_rd = 1'b1;  go_addr = pc_r;
            end else begin
              pc_nxt = rd_r[ADDR_W-1:0];  fin = 1'b1;
            end
          end
          OP_EXECUTE: begin
            if (step_r == 3'd0) begin
              depth_nxt = depth_inc;  rp_nxt = rp_dn;
              go_wr = 1'b1;  go_addr = rp_dn[ADDR_W-1:0];
              go_wdata = CELL_W'(pc_r);
            end else if (step_r == 3'd1) begin
              go_rd = 1'b1;  dp_nxt = dp_dn;
            end else begin
              pc_nxt = rd_r[ADDR_W-1:0];  fin = 1'b1;
            end
          end
          OP_EXIT: begin
            if (step_r == 3'd0) begin
              go_rd = 1'b1;  go_addr = rp_r[ADDR_W-1:0];  rp_nxt = rp_up;
            end else begin
              pc_nxt = rd_r[ADDR_W-1:0];  fin = 1'b1;
              if (depth_r <= 8'd1) begin
                depth_nxt = 8'd0;  run_nxt = 1'b0;  hl_nxt = 1'b1;
              end else begin
                depth_nxt = depth_r - 8'd1;
              end
            end
          end
          OP_STORE, OP_CSTORE: begin
            if (step_r == 3'd0) begin
              go_rd = 1'b1;  dp_nxt = dp_dn;
            end else if (step_r == 3'd1) begin
              b_nxt = rd_r;  go_rd = 1'b1;  dp_nxt = dp_dn;
            end else if (step_r == 3'd2) begin
              go_wr = 1'b1;  go_addr = b_r[ADDR_W-1:0];
              go_len4 = (op_r == OP_STORE);
            end else begin
              fin = 1'b1;
            end
          end
          OP_FETCH, OP_CFETCH: begin
            if (step_r == 3'd0) begin
              go_rd = 1'b1;  dp_nxt = dp_dn;
            end else if (step_r == 3'd1) begin
              go_rd = 1'b1;  go_addr = rd_r[ADDR_W-1:0];
              go_len4 = (op_r == OP_FETCH);
            end else if (step_r == 3'd2) begin
              go_wr = 1'b1;  go_addr = dp_up[ADDR_W-1:0];  dp_nxt = dp_up;
            end else begin
              fin = 1'b1;
            end
          end
          OP_RPFETCH, OP_SPFETCH: begin
            if (step_r == 3'd0) begin
              go_wr = 1'b1;  go_addr = dp_up[ADDR_W-1:0];  dp_nxt = dp_up;
              go_wdata = CELL_W'((op_r == OP_RPFETCH) ? rp_r : dp_r);
            end else begin
              fin = 1'b1;
            end
          end
          OP_RPSTORE, OP_SPSTORE, OP_DROP: begin
            if (step_r == 3'd0) begin
              go_rd = 1'b1;  dp_nxt = dp_dn;
            end else begin
              if (op_r == OP_RPSTORE) begin
                rp_nxt = rd_r[PTR_W-1:0];
              end else if (op_r == OP_SPSTORE) begin
                dp_nxt = rd_r[PTR_W-1:0];
              end
              fin = 1'b1;
            end
          end
          OP_DTOR: begin
            if (step_r == 3'd0) begin
              go_rd = 1'b1;  dp_nxt = dp_dn;
            end else if (step_r == 3'd1) begin
              rp_nxt = rp_dn;  go_wr = 1'b1;  go_addr = rp_dn[ADDR_W-1:0];
            end else begin
              fin = 1'b1;
            end
          end
          OP_RFETCH, OP_RTOD, OP_DUP: begin
            if (step_r == 3'd0) begin
              go_rd = 1'b1;
              if (op_r != OP_DUP) begin
                go_addr = rp_r[ADDR_W-1:0];
              end
              if (op_r == OP_RTOD) begin
                rp_nxt = rp_up;
              end
            end else if (step_r == 3'd1) begin
              go_wr = 1'b1;  go_addr = dp_up[ADDR_W-1:0];  dp_nxt = dp_up;
            end else begin
              fin = 1'b1;
            end
          end
          OP_SWAP, OP_OVER: begin
            if (step_r == 3'd0) begin
              go_rd = 1'b1;  dp_nxt = dp_dn;
            end else if (step_r == 3'd1) begin
              // OVER reads the new top without popping it.
              a_nxt = rd_r;  go_rd = 1'b1;
              if (op_r == OP_SWAP) begin
                dp_nxt = dp_dn;
              end
            end else if (step_r == 3'd2) begin
              b_nxt = rd_r;
              go_wr = 1'b1;  go_addr = dp_up[ADDR_W-1:0];  dp_nxt = dp_up;
              go_wdata = a_r;
            end else if (step_r == 3'd3) begin
              go_wr = 1'b1;  go_addr = dp_up[ADDR_W-1:0];  dp_nxt = dp_up;
              go_wdata = b_r;
            end else begin
              fin = 1'b1;
            end
          end
          OP_AND, OP_OR, OP_XOR, OP_UMPLUS: begin
            if (step_r == 3'd0) begin
              go_rd = 1'b1;  dp_nxt = dp_dn;
            end else if (step_r == 3'd1) begin
              a_nxt = rd_r;  go_rd = 1'b1;
            end else if (step_r == 3'd2) begin
              go_wr = 1'b1;
              case (op_r)
                OP_AND:  go_wdata = rd_r & a_r;
                OP_OR:   go_wdata = rd_r | a_r;
                OP_XOR:  go_wdata = rd_r ^ a_r;
                default: go_wdata = rd_r + a_r;
              endcase
            end else begin
              fin = 1'b1;
            end
          end
          default: begin
            bad_nxt = 1'b1;  fin = 1'b1;
          end
        endcase

        if (fin) begin
          state_nxt = S_IDLE;
          ov_nxt    = 1'b1;
          if (op_r != OP_TX) begin
            cv_nxt = 1'b0;  ch_nxt = 8'd0;
          end
          if (!(op_r == OP_BYE || op_r == OP_EXIT)) begin
            hl_nxt = 1'b0;
          end
          if (op_r <= OP_UMPLUS) begin
            bad_nxt = 1'b0;
          end
        end else begin
          step_nxt = step_r + 3'd1;
          addr_nxt = go_addr;
          len4_nxt = go_len4;
          cnt_nxt  = 3'd0;
          if (go_rd) begin
            state_nxt = S_RD;
            rd_nxt    = '0;
          end else if (go_wr) begin
            state_nxt = S_WR;
            wd_nxt    = go_wdata;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      pc_r    <= '0;
      dp_r    <= DP_RESET;
      rp_r    <= RP_RESET;
      depth_r <= 8'd1;
      run_r   <= 1'b0;
      ov_r    <= 1'b0;
      step_r  <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      pc_r    <= pc_nxt;
      dp_r    <= dp_nxt;
      rp_r    <= rp_nxt;
      depth_r <= depth_nxt;
      run_r   <= run_nxt;
      ov_r    <= ov_nxt;
      step_r  <= step_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    rd_r   <= rd_nxt;
    wd_r   <= wd_nxt;
    addr_r <= addr_nxt;
    len4_r <= len4_nxt;
    cv_r   <= cv_nxt;
    ch_r   <= ch_nxt;
    hl_r   <= hl_nxt;
    bad_r  <= bad_nxt;
  end

  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall)
    else $error("input taken while an instruction is in progress");

  a_load_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_command == CMD_LOAD) |=> (out_valid && !out_char_valid))
    else $error("load transfer did not produce a plain result");

  a_rd_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD) |-> (cnt_r <= cnt_last))
    else $error("cell read ran past its last byte");

endmodule
`default_nettype wire

FILE: test/forth_stack_machine_checker.sv
module forth_stack_machine_checker
  import fsm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic       in_stall,
  input  wire logic [1:0] in_command,
  input  wire logic [11:0] in_address,
  input  wire logic [7:0] in_byte_value,
  input  wire logic       out_valid,
  input  wire logic       out_stall,
  input  wire logic       out_char_valid,
  input  wire logic [7:0] out_char_out,
  input  wire logic       out_halted,
  input  wire logic       out_bad_opcode,
  output int              fail_count,
  output int              pending
);

  typedef struct packed {
    logic       char_valid;
    logic [7:0] char_out;
    logic       halted;
    logic       bad_opcode;
  } vm_result_t;

  logic [7:0]       store [MEM_BYTES];
  logic [11:0]      pc;
  logic [PTR_W-1:0] dp;
  logic [PTR_W-1:0] rp;
  logic [7:0]       depth;
  logic             running;
  vm_result_t       expected_results [$];

  function automatic logic [31:0] read_cell(input logic [31:0] a);
    logic [11:0] base;
    logic [31:0] v;
    base = a[11:0];
    for (int i = 0; i < 4; i++) v[8*i +: 8] = store[base + 12'(i)];
    return v;
  endfunction

  task automatic write_cell(input logic [31:0] a, input logic [31:0] v);
    logic [11:0] base;
    base = a[11:0];
    for (int i = 0; i < 4; i++) store[base + 12'(i)] = v[8*i +: 8];
  endtask

  task automatic push_data(input logic [31:0] v);
    dp = dp + CELL_STEP;
    write_cell(32'(dp), v);
  endtask

  task automatic pop_data(output logic [31:0] v);
    v = read_cell(32'(dp));
    dp = dp - CELL_STEP;
  endtask

  task automatic push_return(input logic [31:0] v);
    rp = rp - CELL_STEP;
    write_cell(32'(rp), v);
  endtask

  task automatic pop_return(output logic [31:0] v);
    v = read_cell(32'(rp));
    rp = rp + CELL_STEP;
  endtask

  task automatic nest_deeper();
    if (depth != 8'd255) depth = depth + 8'd1;
  endtask

  task automatic execute_command(input logic [1:0] cmd, input logic [11:0] addr,
                                 input logic [7:0] bval, output vm_result_t r);
    logic [11:0] npc;
    logic [7:0]  op;
    logic [31:0] a;
    logic [31:0] b;
    r = '0;
    if (cmd == CMD_LOAD) begin
      store[addr] = bval;
    end else if (cmd == CMD_START) begin
      pc = addr;
      depth = 8'd1;
      running = 1'b1;
    end else if (cmd == CMD_STEP && running) begin
      op = store[pc];
      npc = pc + 12'd1;
      case (op) inside
        OP_BYE: begin
          running = 1'b0;
          r.halted = 1'b1;
        end
        OP_QRX, OP_IO, OP_NEXT, OP_LESS: ;
        OP_TX: begin
          pop_data(a);
          r.char_valid = 1'b1;
          r.char_out = a[7:0];
        end
        OP_DOLIT: begin
          push_data(read_cell(32'(npc)));
          npc = npc + 12'd4;
        end
        OP_DOLIST: begin
          a = read_cell(32'(npc));
          push_return(32'(npc + 12'd4));
          npc = a[11:0];
          nest_deeper();
        end
        OP_QBRANCH: begin
          pop_data(b);
          if (b != 0) begin
            a = read_cell(32'(npc));
            npc = a[11:0];
          end else begin
            npc = npc + 12'd4;
          end
        end
        OP_BRANCH: begin
          a = read_cell(32'(npc));
          npc = a[11:0];
        end
        OP_EXECUTE: begin
          nest_deeper();
          push_return(32'(npc));
          pop_data(a);
          npc = a[11:0];
        end
        OP_EXIT: begin
          pop_return(a);
          npc = a[11:0];
          if (depth <= 8'd1) begin
            depth = 8'd0;
            running = 1'b0;
            r.halted = 1'b1;
          end else begin
            depth = depth - 8'd1;
          end
        end
        OP_STORE: begin
          pop_data(b);
          pop_data(a);
          write_cell(b, a);
        end
        OP_FETCH: begin
          pop_data(b);
          push_data(read_cell(b));
        end
        OP_CSTORE: begin
          pop_data(b);
          pop_data(a);
          store[b[11:0]] = a[7:0];
        end
        OP_CFETCH: begin
          pop_data(b);
          push_data(32'(store[b[11:0]]));
        end
        OP_RPFETCH: push_data(32'(rp));
        OP_RPSTORE: begin
          pop_data(a);
          rp = a[PTR_W-1:0];
        end
        OP_DTOR: begin
          pop_data(a);
          push_return(a);
        end
        OP_RFETCH: push_data(read_cell(32'(rp)));
        OP_RTOD: begin
          pop_return(a);
          push_data(a);
        end
        OP_SPFETCH: begin
          a = 32'(dp);
          push_data(a);
        end
        OP_SPSTORE: begin
          pop_data(a);
          dp = a[PTR_W-1:0];
        end
        OP_DROP: pop_data(a);
        OP_DUP: push_data(read_cell(32'(dp)));
        OP_SWAP: begin
          pop_data(a);
          pop_data(b);
          push_data(a);
          push_data(b);
        end
        OP_OVER: begin
          pop_data(a);
          b = read_cell(32'(dp));
          push_data(a);
          push_data(b);
        end
        OP_AND: begin
          pop_data(a);
          write_cell(32'(dp), read_cell(32'(dp)) & a);
        end
        OP_OR: begin
          pop_data(a);
          write_cell(32'(dp), read_cell(32'(dp)) | a);
        end
        OP_XOR: begin
          pop_data(a);
          write_cell(32'(dp), read_cell(32'(dp)) ^ a);
        end
        OP_UMPLUS: begin
          pop_data(a);
          write_cell(32'(dp), read_cell(32'(dp)) + a);
        end
        default: r.bad_opcode = 1'b1;
      endcase
      pc = npc;
    end
  endtask

  always @(posedge clk) begin
    vm_result_t want;
    vm_result_t got;
    if (!rst_n) begin
      for (int i = 0; i < MEM_BYTES; i++) store[i] = 8'd0;
      pc = '0;
      dp = DP_RESET;
      rp = RP_RESET;
      depth = 8'd1;
      running = 1'b0;
      expected_results.delete();
      fail_count <= 0;
    end else begin
      // The result of an item accepted at this edge cannot leave at the same
      // edge, so the output side is handled first.
      if (out_valid && !out_stall) begin
        got = '{out_char_valid, out_char_out, out_halted, out_bad_opcode};
        if (expected_results.size() == 0) begin
          $display("%0t: result transfer with none expected: got %p", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (got.char_valid !== want.char_valid)
            $display("%0t: char_valid expected %0d actual %0d", $time,
                     want.char_valid, got.char_valid);
          if (got.char_out !== want.char_out)
            $display("%0t: char_out expected %0h actual %0h", $time,
                     want.char_out, got.char_out);
          if (got.halted !== want.halted)
            $display("%0t: halted expected %0d actual %0d", $time,
                     want.halted, got.halted);
          if (got.bad_opcode !== want.bad_opcode)
            $display("%0t: bad_opcode expected %0d actual %0d", $time,
                     want.bad_opcode, got.bad_opcode);
          if (got !== want) fail_count <= fail_count + 1;
        end
      end
      if (in_valid && !in_stall) begin
        execute_command(in_command, in_address, in_byte_value, want);
        expected_results.push_back(want);
      end
    end
    pending <= expected_results.size();
  end

endmodule

FILE: test/tb_forth_stack_machine_core.sv
module tb_forth_stack_machine_core;
  import fsm_pkg::*;

  localparam logic [1:0] CMD_IGNORED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_command;
  logic [11:0] in_address;
  logic [7:0]  in_byte_value;
  logic        out_valid;
  logic        out_stall;
  logic        out_char_valid;
  logic [7:0]  out_char_out;
  logic        out_halted;
  logic        out_bad_opcode;
  int          fail_count;
  int          pending;
  int          cycles = 0;
  int          items_sent;
  int          hold_left;
  logic        calm = 1'b0;

  forth_stack_machine_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_command(in_command),
    .in_address(in_address), .in_byte_value(in_byte_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_char_valid(out_char_valid), .out_char_out(out_char_out),
    .out_halted(out_halted), .out_bad_opcode(out_bad_opcode)
  );

  forth_stack_machine_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_command(in_command),
    .in_address(in_address), .in_byte_value(in_byte_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_char_valid(out_char_valid), .out_char_out(out_char_out),
    .out_halted(out_halted), .out_bad_opcode(out_bad_opcode),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
    // Occasionally switch between idling at random and running flat out.
    if ($urandom_range(0, 150) == 0) calm <= ~calm;
  end

  // Result side: a stall length is drawn after every result transfer.
  always @(posedge clk) begin
    int next_hold;
    if (!rst_n) begin
      hold_left = 0;
      out_stall <= 1'b0;
    end else begin
      next_hold = hold_left;
      if (out_valid && !out_stall) next_hold = calm ? 0 : $urandom_range(0, 7);
      else if (next_hold > 0) next_hold = next_hold - 1;
      hold_left = next_hold;
      out_stall <= (next_hold != 0);
    end
  end

  task automatic send(input logic [1:0] cmd, input logic [11:0] addr,
                      input logic [7:0] bval);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_address <= addr;
    in_byte_value <= bval;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic put_cell(input logic [11:0] addr, input logic [31:0] v);
    for (int i = 0; i < 4; i++) send(CMD_LOAD, addr + 12'(i), v[8*i +: 8]);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic logic [31:0] pick_literal(input logic [11:0] base);
    case ($urandom_range(0, 4))
      0: return 32'($urandom_range(0, 255));
      1: return 32'(base) + 32'($urandom_range(0, 48));
      2: return 32'($urandom_range(3800, 4095));
      3: return 32'(DP_RESET) + 32'($urandom_range(0, 64));
      default: return $urandom;
    endcase
  endfunction

  // Loads a random program, starts it and steps it; now and then a byte is
  // changed under the running program, or some noise is sent.
  task automatic run_program();
    logic [7:0]  op;
    logic [11:0] base;
    logic [11:0] at;
    logic [31:0] operand;
    int          len;
    int          steps;
    base = 12'($urandom_range(0, 4095));
    at = base;
    len = $urandom_range(1, 14);
    for (int k = 0; k < len; k++) begin
      op = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(31, 255))
                                          : 8'($urandom_range(0, 30));
      send(CMD_LOAD, at, op);
      at = at + 12'd1;
      if (op == OP_DOLIT || op == OP_DOLIST || op == OP_QBRANCH || op == OP_BRANCH) begin
        operand = (op == OP_DOLIT) ? pick_literal(base)
                                   : 32'(base) + 32'($urandom_range(0, 40));
        if ($urandom_range(0, 9) == 0) operand = $urandom;
        put_cell(at, operand);
        at = at + 12'd4;
      end
    end
    // A word that calls itself drives the nesting depth into saturation.
    if ($urandom_range(0, 40) == 0) begin
      send(CMD_LOAD, base, OP_DOLIST);
      put_cell(base + 12'd1, 32'(base));
      len = 270;
    end
    send(CMD_START, ($urandom_range(0, 9) == 0) ? 12'($urandom_range(0, 4095)) : base, 8'd0);
    steps = len + $urandom_range(0, 10);
    for (int s = 0; s < steps; s++) begin
      case ($urandom_range(0, 30))
        0: send(CMD_LOAD, base + 12'($urandom_range(0, 20)), 8'($urandom_range(0, 255)));
        1: send(CMD_IGNORED, 12'($urandom_range(0, 4095)), 8'($urandom_range(0, 255)));
        default: ;
      endcase
      send(CMD_STEP, 12'($urandom_range(0, 4095)), 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    items_sent = 0;
    in_valid = 1'b0;
    in_command = CMD_LOAD;
    in_address = '0;
    in_byte_value = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: stepping while stopped, the ignored command, the address
    // and byte extremes, an unknown opcode with the counter wrapping to a
    // halt at address zero, and a final return at the outermost level.
    send(CMD_STEP, 12'hfff, 8'hff);
    send(CMD_IGNORED, 12'hfff, 8'hff);
    send(CMD_LOAD, 12'hfff, 8'hff);
    send(CMD_START, 12'hfff, 8'h00);
    send(CMD_STEP, 12'h000, 8'h00);
    send(CMD_STEP, 12'h000, 8'h00);
    send(CMD_STEP, 12'h000, 8'h00);
    send(CMD_LOAD, 12'h010, OP_DOLIT);
    put_cell(12'h011, 32'h8000_0041);
    send(CMD_LOAD, 12'h015, OP_TX);
    send(CMD_LOAD, 12'h016, OP_EXIT);
    send(CMD_START, 12'h010, 8'h00);
    repeat (4) send(CMD_STEP, 12'h000, 8'h00);

    // The sender holds back until every result has come out.
    wait_drained();

    while (items_sent < 1700) run_program();

    wait_drained();
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
